// File: src/svm_pkg.sv
`timescale 1ns / 1ps

package svm_pkg;

    localparam int unsigned VOICES      = 4;
    localparam int unsigned SLOTS       = 31;
    localparam int unsigned SAMPLE_AW   = 17;
    localparam int unsigned SAMPLE_MEM_DEPTH = 1 << SAMPLE_AW;

    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_WR_SAMPLE = 3'd1;
    localparam logic [2:0] OP_WR_SLOT   = 3'd2;
    localparam logic [2:0] OP_TRIGGER   = 3'd3;
    localparam logic [2:0] OP_SET_LEVEL = 3'd4;
    localparam logic [2:0] OP_STOP_ALL  = 3'd5;

    localparam logic       REG_PITCH_SCALE = 1'b0;
    localparam logic       REG_VOICE_EN    = 1'b1;

    localparam logic [6:0]  FULL_LEVEL  = 7'd64;
    localparam logic [15:0] PHASE_STEP  = 16'd75;
    localparam logic [18:0] UNITY_PITCH = 19'h10000;

    typedef struct packed {
        logic [4:0]  slot;
        logic [11:0] period;
        logic [14:0] phase;
        logic [16:0] position;
        logic [6:0]  level;
    } voice_t;

    typedef struct packed {
        logic [16:0] start;
        logic [16:0] length;
        logic [16:0] loop_start;
        logic [16:0] loop_end;
        logic        loops;
        logic [6:0]  volume;
    } slot_t;

    localparam voice_t VOICE_RESET = '{slot: 5'd0, period: 12'd0, phase: 15'd0,
                                       position: 17'd0, level: FULL_LEVEL};

    function automatic logic [6:0] sat_level(input logic [6:0] lv);
        return (lv > FULL_LEVEL) ? FULL_LEVEL : lv;
    endfunction

endpackage

// File: src/svm_sample_mem.sv
`timescale 1ns / 1ps

module svm_sample_mem
    import svm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 we,
    input  logic [SAMPLE_AW-1:0] waddr,
    input  logic [7:0]           wdata,
    input  logic                 re,
    input  logic [SAMPLE_AW-1:0] raddr,
    output logic [7:0]           rdata
);

    logic [7:0] mem [SAMPLE_MEM_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/svm_slot_mem.sv
`timescale 1ns / 1ps

module svm_slot_mem
    import svm_pkg::*;
(
    input  logic       aclk,
    input  logic       we,
    input  logic [4:0] waddr,
    input  slot_t      wdata,
    input  logic       re,
    input  logic [4:0] raddr,
    output slot_t      rdata
);

    slot_t mem [SLOTS];
    slot_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/svm_voice_mem.sv
`timescale 1ns / 1ps

module svm_voice_mem
    import svm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       we,
    input  logic [1:0] waddr,
    input  voice_t     wdata,
    input  logic       re,
    input  logic [1:0] raddr,
    output voice_t     rdata
);

    voice_t     mem [VOICES];
    voice_t     rdata_reg;
    logic [VOICES-1:0] valid_reg;
    logic       rvalid_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    // unwritten entries read as their reset contents
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re) begin
                rvalid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : VOICE_RESET;

endmodule

// File: src/sample_voice_mixer.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// s_*       in         s_valid / s_ready      operation and item fields
// m_*       out        m_valid / m_ready      m_mixed_sample, m_active_mask
// cfg_*     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Non-tick beats finish on acceptance, except set level: it reads, then writes back.
// A tick visits the four voices in turn: start only for a disabled voice, start and voice
// for an idle one, and start, voice, slot, step (per position step), mul and acc for a playing
// one; steps stay within 75 unless a lower pitch scale has shrunk the period limit since
// the last tick. Synchronous active-low reset clears voice activity, config and handshakes;
// memories are not cleared. A held result blocks all beats once the next tick ends.
module sample_voice_mixer
    import svm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_valid,
    output logic         s_ready,
    input  logic [2:0]   s_operation,
    input  logic [1:0]   s_voice_index,
    input  logic [4:0]   s_slot_index,
    input  logic [16:0]  s_address,
    input  logic signed [7:0] s_sample_byte,
    input  logic [16:0]  s_slot_length,
    input  logic [16:0]  s_loop_start,
    input  logic [16:0]  s_loop_end,
    input  logic         s_loop_enable,
    input  logic [6:0]   s_level,
    input  logic [11:0]  s_note_period,

    output logic         m_valid,
    input  logic         m_ready,
    output logic signed [15:0] m_mixed_sample,
    output logic [3:0]   m_active_mask,

    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [18:0]  cfg_data
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_LEVEL = 8'b0000_0010,
        ST_START = 8'b0000_0100,
        ST_VOICE = 8'b0000_1000,
        ST_SLOT  = 8'b0001_0000,
        ST_STEP  = 8'b0010_0000,
        ST_MUL   = 8'b0100_0000,
        ST_ACC   = 8'b1000_0000
    } state_t;

    state_t       state_reg;
    logic         done_reg;       // tick finished, waiting for output slot
    logic [18:0]  pitch_reg;
    logic [3:0]   enable_reg;
    logic [3:0]   active_reg;
    logic [1:0]   vc_reg;
    logic [6:0]   lvl_reg;
    voice_t       vd_reg;
    logic [30:0]  lim_prod_reg;
    logic [14:0]  lim_reg;
    logic [15:0]  phase_reg;
    logic [17:0]  pos_reg;
    logic signed [14:0] prod_reg;
    logic [15:0]  mix_reg;
    logic         m_valid_reg;
    logic [15:0]  m_mix_reg;
    logic [3:0]   m_act_reg;

    // memory ports
    logic                 smp_we, smp_re;
    logic [SAMPLE_AW-1:0] smp_raddr;
    logic [7:0]           smp_rdata;
    logic                 slot_we, slot_re;
    slot_t                slot_wdata, slot_rdata;
    logic                 vm_we, vm_re;
    logic [1:0]           vm_waddr, vm_raddr;
    voice_t               vm_wdata, vm_rdata;

    logic         accept;
    logic [14:0]  lim_raw;
    logic [17:0]  pos_next;
    logic         stop_next;
    logic signed [14:0] prod_adj;
    logic signed [8:0]  quot;
    logic signed [15:0] smp_val;

    assign s_ready   = (state_reg == ST_IDLE) && !done_reg;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign m_valid        = m_valid_reg;
    assign m_mixed_sample = m_mix_reg;
    assign m_active_mask  = m_act_reg;

    // loop wrap then end-of-sample check on the stepped position
    always_comb begin
        pos_next = pos_reg;
        if (slot_rdata.loops && pos_reg >= {1'b0, slot_rdata.loop_end}) begin
            pos_next = {1'b0, slot_rdata.loop_start};
        end
        stop_next = pos_next >= {1'b0, slot_rdata.length};
    end

    assign lim_raw  = lim_prod_reg[30:16];
    // divide by 64 rounding toward zero
    assign prod_adj = prod_reg + ((prod_reg < 0) ? 15'sd63 : 15'sd0);
    assign quot     = 9'(prod_adj >>> 6);
    assign smp_val  = 16'(quot * $signed({9'd0, vd_reg.level == 7'd0 ? 7'd0 : slot_rdata.volume}));

    always_comb begin
        smp_we     = 1'b0;
        smp_re     = 1'b0;
        smp_raddr  = slot_rdata.start + vd_reg.position;
        slot_we    = 1'b0;
        slot_re    = 1'b0;
        slot_wdata = '{start: s_address, length: s_slot_length, loop_start: s_loop_start,
                       loop_end: s_loop_end, loops: s_loop_enable,
                       volume: sat_level(s_level)};
        vm_we      = 1'b0;
        vm_re      = 1'b0;
        vm_waddr   = vc_reg;
        vm_raddr   = vc_reg;
        vm_wdata   = vm_rdata;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_operation)
                        OP_WR_SAMPLE: smp_we = 1'b1;
                        OP_WR_SLOT:   slot_we = (s_slot_index < 5'(SLOTS));
                        OP_TRIGGER: begin
                            vm_we    = (s_note_period != 12'd0) && (s_slot_index < 5'(SLOTS));
                            vm_waddr = s_voice_index;
                            vm_wdata = '{slot: s_slot_index, period: s_note_period,
                                         phase: 15'd0, position: 17'd0,
                                         level: sat_level(s_level)};
                        end
                        OP_SET_LEVEL: begin
                            vm_re    = 1'b1;
                            vm_raddr = s_voice_index;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LEVEL: begin
                vm_we          = 1'b1;
                vm_wdata.level = lvl_reg;
            end
            ST_START: vm_re = enable_reg[vc_reg];
            ST_VOICE: begin
                if (!active_reg[vc_reg]) begin
                    vm_we             = 1'b1;
                    vm_wdata.phase    = 15'd0;
                    vm_wdata.position = 17'd0;
                end else begin
                    slot_re = 1'b1;
                end
            end
            ST_SLOT:  smp_re = 1'b1;
            ST_ACC: begin
                vm_we             = 1'b1;
                vm_wdata          = vd_reg;
                vm_wdata.phase    = stop_next ? 15'd0 : phase_reg[14:0];
                vm_wdata.position = stop_next ? 17'd0 : pos_next[16:0];
            end
            default: ;
        endcase
    end

    // vm_raddr covers set level; slot read follows the voice just fetched
    svm_sample_mem u_sample_mem (
        .aclk  (aclk),
        .we    (smp_we),
        .waddr (s_address),
        .wdata (s_sample_byte),
        .re    (smp_re),
        .raddr (smp_raddr),
        .rdata (smp_rdata)
    );

    svm_slot_mem u_slot_mem (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (s_slot_index),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (vm_rdata.slot),
        .rdata (slot_rdata)
    );

    svm_voice_mem u_voice_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (vm_we),
        .waddr   (vm_waddr),
        .wdata   (vm_wdata),
        .re      (vm_re),
        .raddr   (vm_raddr),
        .rdata   (vm_rdata)
    );

    // config beats
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_reg  <= UNITY_PITCH;
            enable_reg <= 4'hF;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PITCH_SCALE: pitch_reg  <= cfg_data;
                REG_VOICE_EN:    enable_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: lvl_reg <= sat_level(s_level);
            ST_VOICE: begin
                vd_reg       <= vm_rdata;
                lim_prod_reg <= {19'd0, vm_rdata.period} * {12'd0, pitch_reg};
            end
            ST_SLOT: begin
                lim_reg   <= (lim_raw == 15'd0) ? 15'd1 : lim_raw;
                phase_reg <= {1'b0, vd_reg.phase} + PHASE_STEP;
                pos_reg   <= {1'b0, vd_reg.position};
            end
            ST_STEP: begin
                if (phase_reg > {1'b0, lim_reg}) begin
                    phase_reg <= phase_reg - {1'b0, lim_reg};
                    pos_reg   <= pos_reg + 18'd1;
                end
            end
            ST_MUL: prod_reg <= $signed({{7{smp_rdata[7]}}, smp_rdata})
                                * $signed({8'd0, vd_reg.level});
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            done_reg    <= 1'b0;
            active_reg  <= '0;
            vc_reg      <= '0;
            mix_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (done_reg && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
                m_mix_reg   <= mix_reg;
                m_act_reg   <= active_reg;
                done_reg    <= 1'b0;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (s_operation)
                            OP_TICK: begin
                                vc_reg    <= '0;
                                mix_reg   <= '0;
                                state_reg <= ST_START;
                            end
                            OP_TRIGGER: begin
                                if (s_note_period != 12'd0 && s_slot_index < 5'(SLOTS)) begin
                                    active_reg[s_voice_index] <= (s_level != 7'd0);
                                end
                            end
                            OP_SET_LEVEL: begin
                                vc_reg    <= s_voice_index;
                                state_reg <= ST_LEVEL;
                            end
                            OP_STOP_ALL: active_reg <= '0;
                            default: ;
                        endcase
                    end
                end
                ST_LEVEL: begin
                    if (lvl_reg == 7'd0) begin
                        active_reg[vc_reg] <= 1'b0;
                    end
                    state_reg <= ST_IDLE;
                end
                ST_START: begin
                    if (enable_reg[vc_reg]) begin
                        state_reg <= ST_VOICE;
                    end else if (vc_reg == 2'(VOICES - 1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end else begin
                        vc_reg <= vc_reg + 2'd1;
                    end
                end
                ST_VOICE: begin
                    if (active_reg[vc_reg]) begin
                        state_reg <= ST_SLOT;
                    end else if (vc_reg == 2'(VOICES - 1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end else begin
                        vc_reg    <= vc_reg + 2'd1;
                        state_reg <= ST_START;
                    end
                end
                ST_SLOT: state_reg <= ST_STEP;
                ST_STEP: begin
                    if (phase_reg <= {1'b0, lim_reg}) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: state_reg <= ST_ACC;
                ST_ACC: begin
                    mix_reg <= mix_reg + smp_val;
                    if (stop_next) begin
                        active_reg[vc_reg] <= 1'b0;
                    end
                    if (vc_reg == 2'(VOICES - 1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end else begin
                        vc_reg    <= vc_reg + 2'd1;
                        state_reg <= ST_START;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: dv/sample_voice_mixer_checker.sv
`timescale 1ns / 1ps

module sample_voice_mixer_checker
    import svm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [2:0]         s_operation,
    input  logic [1:0]         s_voice_index,
    input  logic [4:0]         s_slot_index,
    input  logic [16:0]        s_address,
    input  logic signed [7:0]  s_sample_byte,
    input  logic [16:0]        s_slot_length,
    input  logic [16:0]        s_loop_start,
    input  logic [16:0]        s_loop_end,
    input  logic               s_loop_enable,
    input  logic [6:0]         s_level,
    input  logic [11:0]        s_note_period,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_mixed_sample,
    input  logic [3:0]         m_active_mask,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [18:0]        cfg_data,
    output int                 mismatches,
    output int                 mixes_pending
);

    typedef struct packed {
        logic [15:0] mix;
        logic [3:0]  act;
    } mix_beat_t;

    logic [7:0]  pcm      [0:SAMPLE_MEM_DEPTH-1];
    slot_t       slot_tab [0:SLOTS-1];
    voice_t      vox      [0:VOICES-1];
    logic [3:0]  playing;
    logic [18:0] pitch;
    logic [3:0]  en_mask;
    mix_beat_t   mix_q [$];

    assign mixes_pending = mix_q.size();

    function automatic logic [6:0] clamp_level(logic [6:0] lv);
        return (lv > 7'd64) ? 7'd64 : lv;
    endfunction

    // One voice through one tick; returns its scaled sample.
    function automatic int render_voice(int v);
        slot_t     sl;
        int        smp;
        longint    lim;
        longint    ph;
        longint    steps;
        longint    pos;
        logic [16:0] rd;
        if (!playing[v]) begin
            vox[v].position = '0;
            vox[v].phase    = '0;
            return 0;
        end
        sl  = slot_tab[vox[v].slot];
        rd  = sl.start + vox[v].position;
        smp = int'($signed(pcm[rd])) * int'(vox[v].level);
        smp = smp / 64;
        smp = smp * int'(sl.volume);
        lim = (longint'(vox[v].period) * longint'(pitch)) >> 16;
        if (lim == 0)
            lim = 1;
        ph    = longint'(vox[v].phase) + 75;
        steps = (ph - 1) / lim;
        ph    = ph - steps * lim;
        pos   = longint'(vox[v].position) + steps;
        if (sl.loops && pos >= sl.loop_end)
            pos = sl.loop_start;
        if (pos >= sl.length) begin
            playing[v] = 1'b0;
            pos = 0;
            ph  = 0;
        end
        vox[v].position = pos[16:0];
        vox[v].phase    = ph[14:0];
        return smp;
    endfunction

    function automatic mix_beat_t run_tick();
        mix_beat_t r;
        r.mix = '0;
        for (int v = 0; v < VOICES; v++)
            if (en_mask[v])
                r.mix = r.mix + 16'(render_voice(v));
        r.act = playing;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int v = 0; v < VOICES; v++)
                vox[v] = VOICE_RESET;
            playing    = '0;
            pitch      = UNITY_PITCH;
            en_mask    = 4'hF;
            mix_q.delete();
            mismatches = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_PITCH_SCALE)
                    pitch = cfg_data;
                else
                    en_mask = cfg_data[3:0];
            end
            if (s_valid && s_ready) begin
                case (s_operation)
                    OP_TICK: mix_q.push_back(run_tick());
                    OP_WR_SAMPLE: pcm[s_address] = s_sample_byte;
                    OP_WR_SLOT: if (s_slot_index < SLOTS) begin
                        slot_tab[s_slot_index] = '{start: s_address, length: s_slot_length,
                            loop_start: s_loop_start, loop_end: s_loop_end,
                            loops: s_loop_enable, volume: clamp_level(s_level)};
                    end
                    OP_TRIGGER: if (s_note_period != 0 && s_slot_index < SLOTS) begin
                        vox[s_voice_index].slot     = s_slot_index;
                        vox[s_voice_index].period   = s_note_period;
                        vox[s_voice_index].level    = clamp_level(s_level);
                        vox[s_voice_index].position = '0;
                        vox[s_voice_index].phase    = '0;
                        playing[s_voice_index] = (s_level != 0);
                    end
                    OP_SET_LEVEL: begin
                        vox[s_voice_index].level = clamp_level(s_level);
                        if (s_level == 0)
                            playing[s_voice_index] = 1'b0;
                    end
                    OP_STOP_ALL: playing = '0;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (mix_q.size() == 0) begin
                    $error("unexpected mix beat: mixed_sample %0d active_mask %h",
                           m_mixed_sample, m_active_mask);
                    mismatches++;
                end else begin
                    if (m_mixed_sample !== $signed(mix_q[0].mix)) begin
                        $error("mixed_sample: expected %0d, got %0d",
                               $signed(mix_q[0].mix), m_mixed_sample);
                        mismatches++;
                    end
                    if (m_active_mask !== mix_q[0].act) begin
                        $error("active_mask: expected %h, got %h",
                               mix_q[0].act, m_active_mask);
                        mismatches++;
                    end
                    void'(mix_q.pop_front());
                end
            end
        end
    end

endmodule

// File: dv/sample_voice_mixer_tb.sv
`timescale 1ns / 1ps

module sample_voice_mixer_tb;
    import svm_pkg::*;

    // Bytes at 0..31 and at the top of memory are always loaded first; every slot
    // that may be triggered starts in 0..15 or in the top eight bytes and reads at
    // most 17 bytes on from there, wrapping, so no unloaded byte is ever played.
    localparam logic [16:0] TOP_BASE = 17'd131064;
    localparam int unsigned SETTLE   = 400;   // margin once every mix beat is back

    typedef struct {
        logic [2:0]  op;
        logic [1:0]  voice;
        logic [4:0]  slot;
        logic [16:0] addr;
        logic [7:0]  byte_val;
        logic [16:0] len;
        logic [16:0] lp_start;
        logic [16:0] lp_end;
        logic        lp_en;
        logic [6:0]  lvl;
        logic [11:0] period;
    } mixer_cmd_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_operation = '0;
    logic [1:0]         s_voice_index = '0;
    logic [4:0]         s_slot_index = '0;
    logic [16:0]        s_address = '0;
    logic signed [7:0]  s_sample_byte = '0;
    logic [16:0]        s_slot_length = '0;
    logic [16:0]        s_loop_start = '0;
    logic [16:0]        s_loop_end = '0;
    logic               s_loop_enable = 1'b0;
    logic [6:0]         s_level = '0;
    logic [11:0]        s_note_period = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_mixed_sample;
    logic [3:0]         m_active_mask;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = REG_PITCH_SCALE;
    logic [18:0]        cfg_data = '0;

    int  mismatches;
    int  mixes_pending;
    int  burst_left = 0;
    bit  slot_loaded [0:SLOTS-1];
    bit  smooth_rx = 1'b1;
    int  rx_mode_left = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    sample_voice_mixer dut (.*);

    sample_voice_mixer_checker u_chk (.*);

    // Receiver: alternates between runs of constant ready and runs of random stalls.
    always @(posedge aclk) begin
        if (rx_mode_left == 0) begin
            smooth_rx    <= $urandom_range(0, 2) == 0;
            rx_mode_left <= $urandom_range(20, 120);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        m_ready <= smooth_rx ? 1'b1 : ($urandom_range(0, 2) != 0);
    end

    // Sender: bursts of beats with random gaps; valid stays up inside a burst.
    task automatic send_cmd(input mixer_cmd_t c);
        if (burst_left == 0) begin
            int gap;
            gap = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 16);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_operation   <= c.op;
        s_voice_index <= c.voice;
        s_slot_index  <= c.slot;
        s_address     <= c.addr;
        s_sample_byte <= c.byte_val;
        s_slot_length <= c.len;
        s_loop_start  <= c.lp_start;
        s_loop_end    <= c.lp_end;
        s_loop_enable <= c.lp_en;
        s_level       <= c.lvl;
        s_note_period <= c.period;
        do @(posedge aclk); while (!s_ready);
        if (c.op == OP_WR_SLOT && c.slot < SLOTS)
            slot_loaded[c.slot] = 1'b1;
    endtask

    function automatic mixer_cmd_t blank_cmd(logic [2:0] op);
        mixer_cmd_t c;
        c = '{op: op, voice: 2'd0, slot: 5'd0, addr: 17'd0, byte_val: 8'd0, len: 17'd0,
              lp_start: 17'd0, lp_end: 17'd0, lp_en: 1'b0, lvl: 7'd64, period: 12'd0};
        return c;
    endfunction

    function automatic mixer_cmd_t byte_cmd(logic [16:0] a, logic [7:0] d);
        mixer_cmd_t c;
        c = blank_cmd(OP_WR_SAMPLE);
        c.addr = a;
        c.byte_val = d;
        return c;
    endfunction

    function automatic mixer_cmd_t slot_cmd(logic [4:0] s, logic [16:0] st, logic [16:0] ln,
                                            logic [16:0] ls, logic [16:0] le, logic lp,
                                            logic [6:0] vol);
        mixer_cmd_t c;
        c = blank_cmd(OP_WR_SLOT);
        c.slot = s; c.addr = st; c.len = ln; c.lp_start = ls; c.lp_end = le;
        c.lp_en = lp; c.lvl = vol;
        return c;
    endfunction

    function automatic mixer_cmd_t voice_cmd(logic [2:0] op, logic [1:0] v, logic [4:0] s,
                                             logic [11:0] per, logic [6:0] lv);
        mixer_cmd_t c;
        c = blank_cmd(op);
        c.voice = v; c.slot = s; c.period = per; c.lvl = lv;
        return c;
    endfunction

    // Slot descriptor whose playback stays inside the loaded sample window.
    function automatic mixer_cmd_t random_slot_cmd();
        logic [16:0] st;
        st = ($urandom_range(0, 1) != 0) ? 17'($urandom_range(0, 15))
                                         : TOP_BASE + 17'($urandom_range(0, 7));
        if ($urandom_range(0, 1) != 0)
            return slot_cmd(5'($urandom_range(0, SLOTS - 1)), st, 17'($urandom_range(0, 16)),
                            17'($urandom), 17'($urandom), 1'b0,
                            7'($urandom_range(0, 127)));
        return slot_cmd(5'($urandom_range(0, SLOTS - 1)), st, 17'($urandom),
                        17'($urandom_range(0, 16)), 17'($urandom_range(0, 16)), 1'b1,
                        7'($urandom_range(0, 127)));
    endfunction

    function automatic mixer_cmd_t random_cmd();
        mixer_cmd_t c;
        int pick;
        int tries;
        logic [4:0] s;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return blank_cmd(OP_TICK);
        if (pick < 55) begin
            // trigger a loaded slot; occasionally period 0 or slot 31, both ignored
            s = 5'($urandom_range(0, SLOTS - 1));
            tries = 0;
            while (!slot_loaded[s] && tries < 40) begin
                s = 5'($urandom_range(0, SLOTS - 1));
                tries++;
            end
            if (!slot_loaded[s])
                s = 5'd0;
            c = voice_cmd(OP_TRIGGER, 2'($urandom), s, 12'($urandom_range(1, 4095)),
                          ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 64)));
            if ($urandom_range(0, 19) == 0)
                c.period = 12'd0;
            else if ($urandom_range(0, 19) == 0)
                c.slot = 5'd31;
            if ($urandom_range(0, 3) == 0)
                c.period = 12'($urandom_range(1, 40));
            return c;
        end
        if (pick < 65)
            return voice_cmd(OP_SET_LEVEL, 2'($urandom), 5'($urandom), 12'($urandom),
                             ($urandom_range(0, 5) == 0) ? 7'd0 : 7'($urandom));
        if (pick < 74)
            return random_slot_cmd();
        if (pick < 77) begin
            // ignored slot index: any field values
            c = slot_cmd(5'd31, 17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom),
                         1'($urandom), 7'($urandom));
            return c;
        end
        if (pick < 93)
            return byte_cmd(($urandom_range(0, 1) != 0) ? 17'($urandom)
                                                        : 17'($urandom_range(0, 31)),
                            8'($urandom));
        if (pick < 97)
            return blank_cmd(OP_STOP_ALL);
        c = blank_cmd(3'($urandom_range(6, 7)));
        c.addr = 17'($urandom);
        return c;
    endfunction

    // Registers change only with the block quiet and every mix beat returned.
    task automatic write_reg(input logic idx, input logic [18:0] val);
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        wait (mixes_pending == 0);
        repeat (SETTLE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Load the playback window: extremes first, then random bytes.
        send_cmd(byte_cmd(17'd0, 8'h7F));
        send_cmd(byte_cmd(17'd131071, 8'h80));
        for (int a = 1; a < 32; a++)
            send_cmd(byte_cmd(17'(a), 8'($urandom)));
        for (int a = 0; a < 7; a++)
            send_cmd(byte_cmd(TOP_BASE + 17'(a), 8'($urandom)));

        // Directed: plain slot, slot wrapping the top of memory with a loop and the
        // longest length, over-range volume, ignored slot index.
        send_cmd(slot_cmd(5'd0, 17'd0, 17'd16, 17'd0, 17'd0, 1'b0, 7'd64));
        send_cmd(slot_cmd(5'd1, 17'd131068, 17'h1FFFF, 17'd2, 17'd6, 1'b1, 7'd64));
        send_cmd(slot_cmd(5'd30, 17'd3, 17'd0, 17'd0, 17'd0, 1'b0, 7'd127));
        send_cmd(slot_cmd(5'd31, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 1'b1, 7'd127));
        send_cmd(voice_cmd(OP_TRIGGER, 2'd0, 5'd0, 12'd1, 7'd64));
        send_cmd(voice_cmd(OP_TRIGGER, 2'd1, 5'd1, 12'd4095, 7'd127));
        send_cmd(voice_cmd(OP_TRIGGER, 2'd2, 5'd30, 12'd100, 7'd64));
        send_cmd(voice_cmd(OP_TRIGGER, 2'd3, 5'd0, 12'd50, 7'd0));   // level 0: stays idle
        send_cmd(voice_cmd(OP_TRIGGER, 2'd3, 5'd1, 12'd0, 7'd64));   // period 0: ignored
        send_cmd(voice_cmd(OP_TRIGGER, 2'd3, 5'd31, 12'd9, 7'd64));  // slot 31: ignored
        repeat (4) send_cmd(blank_cmd(OP_TICK));
        send_cmd(voice_cmd(OP_SET_LEVEL, 2'd1, 5'd0, 12'd0, 7'd0));
        send_cmd(voice_cmd(OP_SET_LEVEL, 2'd0, 5'd0, 12'd0, 7'd127));
        send_cmd(blank_cmd(OP_TICK));
        send_cmd(blank_cmd(OP_STOP_ALL));
        send_cmd(blank_cmd(OP_TICK));
        send_cmd(blank_cmd(3'd6));
        send_cmd(blank_cmd(3'd7));
        send_cmd(blank_cmd(OP_TICK));

        // Random phases over several register settings, extremes included.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_PITCH_SCALE, 19'd16384);
                    write_reg(REG_VOICE_EN, 19'hF);
                end
                1: write_reg(REG_PITCH_SCALE, 19'd262144);
                2: begin
                    write_reg(REG_PITCH_SCALE, 19'd65536);
                    write_reg(REG_VOICE_EN, 19'h0);
                end
                3: write_reg(REG_VOICE_EN, 19'h5);
                default: begin
                    write_reg(REG_PITCH_SCALE, 19'($urandom_range(16384, 262144)));
                    write_reg(REG_VOICE_EN, 19'($urandom_range(0, 15)));
                end
            endcase
            repeat (115) send_cmd(random_cmd());
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        wait (mixes_pending == 0);
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0 && mixes_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
